// ----- design/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int MOVE_COUNT = (ROWS - 1) * COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = (ROWS > 2) ? $clog2(ROWS) : 1;

  localparam int ACTION_W = 2;
  localparam int CHAR_W   = 8;
  localparam int INDEX_W  = 11;
  localparam int CELL_W   = 16;
  localparam int OCOL_W   = 7;
  localparam int OROW_W   = 5;
  localparam int ATTR_W   = 8;

  localparam logic [CHAR_W-1:0] BLANK_CHAR     = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR   = 8'h0A;
  localparam logic [ATTR_W-1:0] RESET_ATTR     = 8'h0F;
  localparam logic [CELL_W-1:0] RESET_BLANK    = {RESET_ATTR, BLANK_CHAR};

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUT   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2
  } action_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_PUT,
    ST_READ,
    ST_SCROLL,
    ST_SCROLL_END,
    ST_FILL,
    ST_POST
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

// ----- design/tcw_if.sv -----
// ----------------------------------------------------------------------------
// tcw_if
// Valid/ready channels of the text console writer: input items and results.
// ----------------------------------------------------------------------------
interface tcw_in_if
  import tcw_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [CHAR_W-1:0]   char_code;
  logic [INDEX_W-1:0]  cell_index;

  modport source (output valid, action, char_code, cell_index, input ready);
  modport sink   (input valid, action, char_code, cell_index, output ready);
endinterface

interface tcw_out_if
  import tcw_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_word;
  logic [OCOL_W-1:0] cursor_col;
  logic [OROW_W-1:0] cursor_row;
  logic              scrolled;

  modport source (output valid, cell_word, cursor_col, cursor_row, scrolled, input ready);
  modport sink   (input valid, cell_word, cursor_col, cursor_row, scrolled, output ready);
endinterface

// ----- design/text_console_writer.sv -----
// ----------------------------------------------------------------------------
// text_console_writer
// Text console: COLUMNS x ROWS screen of attribute/character cells, cursor.
// ----------------------------------------------------------------------------
// One item at a time. A put or a read goes through ST_PUT or ST_READ, then
// ST_POST, which waits for the output register; an unused action goes
// straight to ST_POST. A clear writes one cell a cycle through the single RAM
// write port. A put that scrolls moves the rows up one cell a cycle through
// the shared address counter, then fills the bottom row. After reset the
// block runs a clearing pass over all CELL_COUNT cells (2000 at 80x25)
// before taking its first item; attribute writes are taken during that pass.
// A finished result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module text_console_writer
  import tcw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [ATTR_W-1:0] cfg_wr_data,
  tcw_in_if.sink            in_ch,
  tcw_out_if.source         out_ch
);

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [ATTR_W-1:0] attr_r;
  logic [CHAR_W-1:0] ch_r, ch_nxt;
  logic              hit_r, hit_nxt;
  logic [CELL_W-1:0] word_r, word_nxt;
  logic              scr_r, scr_nxt;
  logic              out_valid_r;
  logic [CELL_W-1:0] out_word_r;
  logic [OCOL_W-1:0] out_col_r;
  logic [OROW_W-1:0] out_row_r;
  logic              out_scr_r;
  logic              load_out;

  ram_req_t          ram_req;
  logic [CELL_W-1:0] ram_rdata;

  logic [COL_W:0]    col_inc;
  logic [ROW_W:0]    row_inc;
  logic [ADDR_W-1:0] put_pos;
  logic [CELL_W-1:0] cur_blank;

  tcw_cell_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  assign col_inc   = {1'b0, col_r} + (COL_W+1)'(1);
  assign row_inc   = {1'b0, row_r} + (ROW_W+1)'(1);
  assign put_pos   = ADDR_W'(ADDR_W'(row_r) * ADDR_W'(COLUMNS) + ADDR_W'(col_r));
  assign cur_blank = {attr_r, BLANK_CHAR};

  assign in_ch.ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    ch_nxt    = ch_r;
    hit_nxt   = hit_r;
    word_nxt  = word_r;
    scr_nxt   = scr_r;
    load_out  = 1'b0;
    ram_req   = '0;
    case (state_r)
      ST_INIT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = addr_r;
        ram_req.wdata = RESET_BLANK;
        if (addr_r == ADDR_W'(CELL_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          addr_nxt = addr_r + ADDR_W'(1);
        end
      end
      ST_IDLE: begin
        if (in_ch.valid) begin
          ch_nxt   = in_ch.char_code;
          word_nxt = '0;
          scr_nxt  = 1'b0;
          case (in_ch.action)
            ACT_PUT: begin
              state_nxt = ST_PUT;
            end
            ACT_CLEAR: begin
              addr_nxt  = '0;
              col_nxt   = '0;
              row_nxt   = '0;
              state_nxt = ST_FILL;
            end
            ACT_READ: begin
              hit_nxt       = (32'(in_ch.cell_index) < CELL_COUNT);
              ram_req.re    = 1'b1;
              ram_req.raddr = ADDR_W'(in_ch.cell_index);
              state_nxt     = ST_READ;
            end
            default: begin
              state_nxt = ST_POST;
            end
          endcase
        end
      end
      ST_PUT: begin
        state_nxt = ST_POST;
        if (ch_r == NEWLINE_CHAR) begin
          col_nxt = '0;
          row_nxt = ROW_W'(row_inc);
        end else begin
          ram_req.we    = 1'b1;
          ram_req.waddr = put_pos;
          ram_req.wdata = {attr_r, ch_r};
          if (col_inc >= (COL_W+1)'(COLUMNS)) begin
            col_nxt = '0;
            row_nxt = ROW_W'(row_inc);
          end else begin
            col_nxt = COL_W'(col_inc);
          end
        end
        if ((ch_r == NEWLINE_CHAR || col_inc >= (COL_W+1)'(COLUMNS)) &&
            row_inc >= (ROW_W+1)'(ROWS)) begin
          row_nxt   = ROW_W'(ROWS - 1);
          scr_nxt   = 1'b1;
          addr_nxt  = '0;
          state_nxt = ST_SCROLL;
        end
      end
      ST_READ: begin
        word_nxt  = hit_r ? ram_rdata : '0;
        state_nxt = ST_POST;
      end
      ST_SCROLL: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = addr_r + ADDR_W'(COLUMNS);
        ram_req.we    = (addr_r != '0);
        ram_req.waddr = addr_r - ADDR_W'(1);
        ram_req.wdata = ram_rdata;
        if (addr_r == ADDR_W'(MOVE_COUNT - 1)) begin
          state_nxt = ST_SCROLL_END;
        end else begin
          addr_nxt = addr_r + ADDR_W'(1);
        end
      end
      ST_SCROLL_END: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = addr_r;
        ram_req.wdata = ram_rdata;
        addr_nxt      = addr_r + ADDR_W'(1);
        state_nxt     = ST_FILL;
      end
      ST_FILL: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = addr_r;
        ram_req.wdata = cur_blank;
        if (addr_r == ADDR_W'(CELL_COUNT - 1)) begin
          state_nxt = ST_POST;
        end else begin
          addr_nxt = addr_r + ADDR_W'(1);
        end
      end
      ST_POST: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      addr_r      <= '0;
      col_r       <= '0;
      row_r       <= '0;
      attr_r      <= RESET_ATTR;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      if (cfg_wr_en) begin
        attr_r <= cfg_wr_data;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ch_r   <= ch_nxt;
    hit_r  <= hit_nxt;
    word_r <= word_nxt;
    scr_r  <= scr_nxt;
    if (load_out) begin
      out_word_r <= word_r;
      out_col_r  <= OCOL_W'(col_r);
      out_row_r  <= OROW_W'(row_r);
      out_scr_r  <= scr_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.cell_word  = out_word_r;
  assign out_ch.cursor_col = out_col_r;
  assign out_ch.cursor_row = out_row_r;
  assign out_ch.scrolled   = out_scr_r;

endmodule

// ----- design/tcw_cell_ram.sv -----
// ----------------------------------------------------------------------------
// tcw_cell_ram
// Screen cell store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tcw_cell_ram
  import tcw_pkg::*;
(
  input  logic              clk,
  input  ram_req_t          req,
  output logic [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [CELL_COUNT];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for text_console_writer. A shadow screen and cursor
// are updated on every input transfer and predict each result; the results
// are checked field by field in order. Directed cases cover reset contents,
// byte extremes, newline, unused action, out-of-range reads and clear with a
// new attribute. Random text with newlines, reads, clears and unused actions
// follows under several attributes, with bursty input and a stalling output.
// ----------------------------------------------------------------------------
module testbench;
  import tcw_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int QUIET_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_PRINTED  = 40;
  localparam int PHASE_ITEMS  = 100;

  typedef struct packed {
    logic [CELL_W-1:0] cell_word;
    logic [OCOL_W-1:0] cursor_col;
    logic [OROW_W-1:0] cursor_row;
    logic              scrolled;
  } console_report_t;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              cfg_wr_en   = 1'b0;
  logic [ATTR_W-1:0] cfg_wr_data = '0;

  tcw_in_if  in_ch();
  tcw_out_if out_ch();

  text_console_writer u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  always #10 clk = ~clk;

  logic [CELL_W-1:0] shadow_screen [CELL_COUNT];
  int unsigned       shadow_col;
  int unsigned       shadow_row;
  logic [ATTR_W-1:0] shadow_attr;

  console_report_t cursor_reports [$];
  console_report_t got_report;
  console_report_t want_report;

  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned burst_left     = 0;
  int unsigned ready_tick     = 0;
  int          ready_mode     = 0;

  function automatic void blank_from(int unsigned first_idx);
    for (int unsigned i = first_idx; i < CELL_COUNT; i++) begin
      shadow_screen[i] = {shadow_attr, BLANK_CHAR};
    end
  endfunction

  function automatic console_report_t apply_console_action(
    logic [ACTION_W-1:0] act,
    logic [CHAR_W-1:0]   ch,
    logic [INDEX_W-1:0]  idx
  );
    console_report_t r;
    int unsigned     pos;
    r = '0;
    if (act == ACT_PUT) begin
      if (ch == NEWLINE_CHAR) begin
        shadow_col = 0;
        shadow_row++;
      end else begin
        pos = shadow_row * COLUMNS + shadow_col;
        if (pos < CELL_COUNT) begin
          shadow_screen[pos] = {shadow_attr, ch};
        end
        shadow_col++;
      end
      if (shadow_col >= COLUMNS) begin
        shadow_col = 0;
        shadow_row++;
      end
      if (shadow_row >= ROWS) begin
        for (int unsigned i = 0; i < MOVE_COUNT; i++) begin
          shadow_screen[i] = shadow_screen[i + COLUMNS];
        end
        blank_from(MOVE_COUNT);
        shadow_row = ROWS - 1;
        r.scrolled = 1'b1;
      end
    end else if (act == ACT_CLEAR) begin
      blank_from(0);
      shadow_col = 0;
      shadow_row = 0;
    end else if (act == ACT_READ) begin
      if (idx < CELL_COUNT) begin
        r.cell_word = shadow_screen[idx];
      end
    end
    r.cursor_col = OCOL_W'(shadow_col);
    r.cursor_row = OROW_W'(shadow_row);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("%0t mismatch %s: want 0x%0h got 0x%0h", $time, what, want, got);
    end
  endtask

  task automatic send_item(input logic [ACTION_W-1:0] act, input logic [CHAR_W-1:0] ch,
                           input logic [INDEX_W-1:0] idx);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= act;
    in_ch.char_code  <= ch;
    in_ch.cell_index <= idx;
    do @(posedge clk); while (!in_ch.ready);
    cursor_reports.push_back(apply_console_action(act, ch, idx));
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic settle();
    stop_sending();
    while (cursor_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_attribute(input logic [ATTR_W-1:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    shadow_attr = value;
  endtask

  function automatic logic [INDEX_W-1:0] pick_read_index();
    int unsigned sel;
    int unsigned back;
    int unsigned row_sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      back    = $urandom_range(0, 4);
      row_sel = (shadow_row > back) ? shadow_row - back : 0;
      return INDEX_W'(row_sel * COLUMNS + $urandom_range(0, COLUMNS - 1));
    end else if (sel < 85) begin
      return INDEX_W'($urandom_range(0, CELL_COUNT - 1));
    end
    return INDEX_W'($urandom_range(CELL_COUNT, (1 << INDEX_W) - 1));
  endfunction

  task automatic test_reset_screen();
    send_item(ACT_READ, 8'h00, '0);
    send_item(ACT_READ, 8'h00, INDEX_W'(CELL_COUNT - 1));
    send_item(ACT_READ, 8'h00, INDEX_W'(CELL_COUNT));
    send_item(ACT_READ, 8'hFF, '1);
  endtask

  task automatic test_put_extremes();
    send_item(ACT_PUT, 8'h00, '0);
    send_item(ACT_PUT, 8'hFF, '1);
    send_item(ACT_PUT, 8'h41, '0);
    send_item(ACT_READ, 8'h00, INDEX_W'(0));
    send_item(ACT_READ, 8'h00, INDEX_W'(1));
    send_item(ACT_READ, 8'h00, INDEX_W'(2));
    send_item(ACT_PUT, NEWLINE_CHAR, '0);
    send_item(ACT_PUT, 8'h7E, '0);
    send_item(ACT_READ, 8'h00, INDEX_W'(COLUMNS));
  endtask

  task automatic test_unused_action();
    send_item(ACT_UNUSED, 8'hFF, '1);
    send_item(ACT_UNUSED, 8'h00, '0);
    send_item(ACT_READ, 8'h00, INDEX_W'(1));
  endtask

  task automatic test_clear_with_attribute();
    settle();
    write_attribute(8'h3C);
    send_item(ACT_CLEAR, 8'h00, '0);
    send_item(ACT_READ, 8'h00, '0);
    send_item(ACT_READ, 8'h00, INDEX_W'(CELL_COUNT - 1));
    send_item(ACT_PUT, 8'h58, '0);
    send_item(ACT_READ, 8'h00, '0);
  endtask

  task automatic run_text_phase(input int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    int unsigned text_len;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        text_len = ($urandom_range(0, 19) == 0) ? $urandom_range(COLUMNS - 5, COLUMNS + 20)
                                                 : $urandom_range(0, 6);
        repeat (text_len) begin
          send_item(ACT_PUT, CHAR_W'($urandom_range(0, 255)),
                    INDEX_W'($urandom_range(0, 2047)));
        end
        send_item(ACT_PUT, NEWLINE_CHAR, INDEX_W'($urandom_range(0, 2047)));
        sent += text_len + 1;
      end else if (pick < 92) begin
        send_item(ACT_READ, CHAR_W'($urandom_range(0, 255)), pick_read_index());
        sent++;
      end else if (pick < 98) begin
        send_item(ACT_UNUSED, CHAR_W'($urandom_range(0, 255)),
                  INDEX_W'($urandom_range(0, 2047)));
        sent++;
      end else begin
        send_item(ACT_CLEAR, CHAR_W'($urandom_range(0, 255)),
                  INDEX_W'($urandom_range(0, 2047)));
        sent++;
      end
    end
  endtask

  task automatic test_random_text();
    logic [ATTR_W-1:0] attrs [5];
    attrs[0] = 8'h00;
    attrs[1] = 8'hFF;
    attrs[2] = ATTR_W'($urandom_range(0, 255));
    attrs[3] = RESET_ATTR;
    attrs[4] = ATTR_W'($urandom_range(0, 255));
    foreach (attrs[k]) begin
      settle();
      write_attribute(attrs[k]);
      run_text_phase(PHASE_ITEMS);
    end
  endtask

  // output stall pattern with a randomly chosen mode
  always @(negedge clk) begin
    ready_tick++;
    if (ready_tick % 97 == 0) begin
      ready_mode = $urandom_range(0, 3);
    end
    case (ready_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= 1'($urandom_range(0, 1));
      2: out_ch.ready <= ($urandom_range(0, 3) == 0);
      default: out_ch.ready <= (ready_tick % 4 != 3);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_report = {out_ch.cell_word, out_ch.cursor_col, out_ch.cursor_row, out_ch.scrolled};
      if (cursor_reports.size() == 0) begin
        report_mismatch("result with nothing pending", '0, 32'(got_report));
      end else begin
        want_report = cursor_reports.pop_front();
        if (got_report.cell_word !== want_report.cell_word)
          report_mismatch("cell_word", 32'(want_report.cell_word),
                          32'(got_report.cell_word));
        if (got_report.cursor_col !== want_report.cursor_col)
          report_mismatch("cursor_col", 32'(want_report.cursor_col),
                          32'(got_report.cursor_col));
        if (got_report.cursor_row !== want_report.cursor_row)
          report_mismatch("cursor_row", 32'(want_report.cursor_row),
                          32'(got_report.cursor_row));
        if (got_report.scrolled !== want_report.scrolled)
          report_mismatch("scrolled", 32'(want_report.scrolled),
                          32'(got_report.scrolled));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_wr_en) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.action     = '0;
    in_ch.char_code  = '0;
    in_ch.cell_index = '0;
    out_ch.ready     = 1'b0;
    shadow_attr      = RESET_ATTR;
    shadow_col       = 0;
    shadow_row       = 0;
    blank_from(0);
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_screen();
    test_put_extremes();
    test_unused_action();
    test_clear_with_attribute();
    test_random_text();

    settle();
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
